>>> hdl/dmm_pkg.sv
// Shared types and constants for the dense matrix multiply core.
package dmm_pkg;

    // Fixed field widths
    localparam int ELEM_W = 16;
    localparam int PRODUCT_W = 32;
    localparam int ACC_W = 40;
    localparam int IDX_W = 3;
    localparam int SIZE_W = 4;

    // Configuration
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
    localparam logic REG_SIZE = 1'b0;

    // Load targets
    localparam logic OP_LOAD_A = 1'b0;
    localparam logic OP_LOAD_B = 1'b1;

    // Input item
    typedef struct packed {
        logic                     op;
        logic signed [ELEM_W-1:0] element;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [ACC_W-1:0] product;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic              wr_left;
        logic              wr_right;
        logic              issue;
        logic              first_k;
        logic              last_k;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  k;
        logic [SIZE_W-1:0] dim;
        logic              load_out;
        logic              last;
    } dmm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic acc_done;
        logic out_free;
    } dmm_status_t;

endpackage

>>> hdl/dmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/dmm_ctrl.sv
// Controller: load counting, element sequencing and k-loop issue.
module dmm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [dmm_pkg::SIZE_W-1:0]             size_cfg,
    input  logic                                   s_valid,
    input  logic                                   s_op,
    output logic                                   s_ready,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     load_addr,
    output dmm_pkg::dmm_cmd_t                      cmd,
    input  dmm_pkg::dmm_status_t                   status
);
    import dmm_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] lcount_reg, lcount_next;
    logic [CNT_W-1:0] rcount_reg, rcount_next;

    logic [SIZE_W-1:0] dim;
    logic [CNT_W-1:0]  full_cnt;
    logic [IDX_W-1:0]  last_idx;
    logic              last_elem;

    // Clamp the size register to 1..MAX_DIM
    always_comb begin
        if (size_cfg == '0) begin
            dim = SIZE_W'(1);
        end else if (size_cfg > SIZE_W'(MAX_DIM)) begin
            dim = SIZE_W'(MAX_DIM);
        end else begin
            dim = size_cfg;
        end
    end

    assign full_cnt  = CNT_W'(dim) * CNT_W'(dim);
    assign last_idx  = IDX_W'(dim - SIZE_W'(1));
    assign last_elem = (row_reg == last_idx) && (col_reg == last_idx);

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        k_next      = k_reg;
        lcount_next = lcount_reg;
        rcount_next = rcount_reg;
        s_ready     = 1'b0;
        load_addr   = '0;

        cmd          = '0;
        cmd.row      = row_reg;
        cmd.col      = col_reg;
        cmd.k        = k_reg;
        cmd.dim      = dim;
        cmd.first_k  = (k_reg == '0);
        cmd.last_k   = (k_reg == last_idx);
        cmd.last     = last_elem;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_LOAD_A) begin
                        if (lcount_reg < full_cnt) begin
                            cmd.wr_left = 1'b1;
                            load_addr   = lcount_reg[ADDR_W-1:0];
                            lcount_next = lcount_reg + CNT_W'(1);
                        end
                    end else if (rcount_reg < full_cnt) begin
                        cmd.wr_right = 1'b1;
                        load_addr    = rcount_reg[ADDR_W-1:0];
                        if (rcount_reg + CNT_W'(1) == full_cnt) begin
                            // B complete: start the product, rearm the loads
                            lcount_next = '0;
                            rcount_next = '0;
                            row_next    = '0;
                            col_next    = '0;
                            k_next      = '0;
                            state_next  = ST_ISSUE;
                        end else begin
                            rcount_next = rcount_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (k_reg == last_idx) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (status.acc_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    k_next = '0;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ISSUE;
                        if (col_reg == last_idx) begin
                            col_next = '0;
                            row_next = row_reg + IDX_W'(1);
                        end else begin
                            col_next = col_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            k_reg      <= '0;
            lcount_reg <= '0;
            rcount_reg <= '0;
        end else begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            k_reg      <= k_next;
            lcount_reg <= lcount_next;
            rcount_reg <= rcount_next;
        end
    end

endmodule

>>> hdl/dmm_datapath.sv
// Datapath: operand stores, multiply-accumulate pipeline and output register.
module dmm_datapath #(
    parameter int MAX_DIM = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  dmm_pkg::dmm_cmd_t                      cmd,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     load_addr,
    input  logic signed [dmm_pkg::ELEM_W-1:0]      element,
    output dmm_pkg::dmm_status_t                   status,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output dmm_pkg::out_item_t                     m_item
);
    import dmm_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W = 2 * IDX_W + 1;

    logic [LIN_W-1:0]  a_lin, b_lin;
    logic [ELEM_W-1:0] a_rd, b_rd;

    logic rd_vld_reg, rd_first_reg, rd_last_reg;
    logic prod_vld_reg, prod_first_reg, prod_last_reg;
    logic signed [PRODUCT_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic                        done_reg;
    logic                        out_valid_reg;
    out_item_t                   out_reg;

    // Row-major read addresses: A[row][k] and B[k][col]
    assign a_lin = LIN_W'(cmd.row) * LIN_W'(cmd.dim) + LIN_W'(cmd.k);
    assign b_lin = LIN_W'(cmd.k) * LIN_W'(cmd.dim) + LIN_W'(cmd.col);

    dmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CELLS)
    ) u_left_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_left),
        .wr_addr (load_addr),
        .wr_data (element),
        .rd_addr (a_lin[ADDR_W-1:0]),
        .rd_data (a_rd)
    );

    dmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CELLS)
    ) u_right_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_right),
        .wr_addr (load_addr),
        .wr_data (element),
        .rd_addr (b_lin[ADDR_W-1:0]),
        .rd_data (b_rd)
    );

    // Pipeline control: read, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
            done_reg     <= prod_vld_reg && prod_last_reg;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        rd_first_reg   <= cmd.first_k;
        rd_last_reg    <= cmd.last_k;
        prod_first_reg <= rd_first_reg;
        prod_last_reg  <= rd_last_reg;
        prod_reg       <= $signed(a_rd) * $signed(b_rd);
        if (prod_vld_reg) begin
            if (prod_first_reg) begin
                acc_reg <= ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
        if (cmd.load_out) begin
            out_reg.product <= acc_reg;
            out_reg.row     <= cmd.row;
            out_reg.col     <= cmd.col;
            out_reg.last    <= cmd.last;
        end
    end

    assign status.acc_done = done_reg;
    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

>>> hdl/dense_matrix_multiply_core.sv
// Top level of the dense matrix multiply core: APB register, controller, datapath.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    in_item_t  {op, element}
//  m_       out        m_valid/m_ready    out_item_t {product, row, col, last}
//  APB      in/out     psel/penable       size register at byte address 0
//
// The core accepts loads while idle. The load that completes B starts the product;
// for each element of C the controller then issues N reads of the operand RAMs
// (one port per matrix), which pass three pipeline stages before the output push.
// Input is stalled while the product runs; it reopens once the last element
// sits in the output register. A held output register holds the next push.
// Reset is synchronous; the operand RAMs are not cleared.
module dense_matrix_multiply_core #(
    parameter int MAX_DIM = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dmm_pkg::in_item_t     s_item,
    // Result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output dmm_pkg::out_item_t    m_item,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import dmm_pkg::*;

    logic [SIZE_W-1:0]                  size_reg;
    logic                               cfg_wr;
    logic [$clog2(MAX_DIM*MAX_DIM)-1:0] load_addr;
    dmm_cmd_t                           cmd;
    dmm_status_t                        status;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SIZE) ? {{(32-SIZE_W){1'b0}}, size_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_wr && paddr[2] == REG_SIZE) begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    dmm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .size_cfg    (size_reg),
        .s_valid     (s_valid),
        .s_op        (s_item.op),
        .s_ready     (s_ready),
        .load_addr   (load_addr),
        .cmd         (cmd),
        .status      (status)
    );

    dmm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .load_addr (load_addr),
        .element   (s_item.element),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // No loads while the product is being computed
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !s_ready)
        else $error("operand read issued while input is open");

    // Stores are written only by accepted items
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_left || cmd.wr_right) |-> (s_valid && s_ready))
        else $error("store written without an accepted item");

    // Output register is never overwritten while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result overwritten before it was taken");

    // The accumulator finishes only after the k loop has stopped issuing
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.acc_done |-> !cmd.issue)
        else $error("accumulation finished during issue");

endmodule

>>> bench/tb_dense_matrix_multiply_core.sv
// Self-checking testbench for the dense matrix multiply core: directed table, random products.
`timescale 1ns / 1ps

module tb_dense_matrix_multiply_core;
    import dmm_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int RANDOM_ITEMS = 20;
    localparam int SETTLE_CYCLES = 2 * (MAX_DIM + 5) + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 50;
    localparam logic [2:0] SIZE_ADDR = 3'(4 * int'(REG_SIZE));

    // Directed table
    typedef enum logic {STEP_CONFIG, STEP_LOAD} step_kind_e;

    typedef struct packed {
        step_kind_e              kind;
        logic                    op;
        logic signed [ELEM_W-1:0] element;
        logic [SIZE_W-1:0]       size;
        logic                    typed;
        logic signed [ACC_W-1:0] product;
    } step_t;

    localparam int DIRECTED_STEPS = 27;

    step_t directed_steps [DIRECTED_STEPS] = '{
        // 1x1: extremes of the element range
        '{STEP_CONFIG, OP_LOAD_A, 16'h0000, 4'd1, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_A, 16'h8000, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'h8000, 4'd0, 1'b1, 40'sd1073741824},
        '{STEP_LOAD,   OP_LOAD_A, 16'h7FFF, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'h8000, 4'd0, 1'b1, -40'sd1073709056},
        '{STEP_LOAD,   OP_LOAD_A, 16'h7FFF, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'h7FFF, 4'd0, 1'b1, 40'sd1073676289},
        // A full: second load of A is dropped
        '{STEP_LOAD,   OP_LOAD_A, 16'h0100, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_A, 16'hFFFF, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'h0200, 4'd0, 1'b1, 40'sd131072},
        // B alone: A keeps its old contents
        '{STEP_LOAD,   OP_LOAD_B, 16'hFF00, 4'd0, 1'b1, -40'sd65536},
        // size zero behaves as one
        '{STEP_CONFIG, OP_LOAD_A, 16'h0000, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_A, 16'h0003, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'hFFFB, 4'd0, 1'b1, -40'sd15},
        // 2x2 with extremes, checked by the predictor
        '{STEP_CONFIG, OP_LOAD_A, 16'h0000, 4'd2, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_A, 16'h7FFF, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_A, 16'h8000, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_A, 16'h0001, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_A, 16'hFFFF, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'h8000, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'h7FFF, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'h0100, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'hFFFF, 4'd0, 1'b0, 40'sd0},
        // size shrunk part-way through loading A
        '{STEP_LOAD,   OP_LOAD_A, 16'h0064, 4'd0, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_A, 16'h00C8, 4'd0, 1'b0, 40'sd0},
        '{STEP_CONFIG, OP_LOAD_A, 16'h0000, 4'd1, 1'b0, 40'sd0},
        '{STEP_LOAD,   OP_LOAD_B, 16'h0007, 4'd0, 1'b1, 40'sd700}
    };

    // DUT connections
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state
    logic signed [ELEM_W-1:0] left_store [CELLS];
    logic signed [ELEM_W-1:0] right_store [CELLS];
    int unsigned              left_cnt;
    int unsigned              right_cnt;
    int unsigned              left_written;   // entries of A written since reset
    logic [SIZE_W-1:0]        size_reg;
    out_item_t                product_q [$];

    // Run bookkeeping
    int          error_count = 0;
    int          cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned elements_seen = 0;
    int unsigned products_seen = 0;
    bit          quiet = 1'b0;
    out_item_t   elem_want;

    dense_matrix_multiply_core #(
        .MAX_DIM (MAX_DIM)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 250 MHz clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Size in force: zero acts as one, anything above the maximum as the maximum
    function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_DIM)
            return MAX_DIM;
        return 32'(s);
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [ELEM_W-1:0] rand_element();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 50)
            return 16'(int'($urandom_range(0, 2047)) - 1024);
        return 16'($urandom);
    endfunction

    // Apply one accepted load; queue every element of C it triggers
    task automatic predict_load(input in_item_t it, output int unsigned made);
        int unsigned n;
        int unsigned full;
        longint      acc;
        out_item_t   r;
        n = eff_dim(size_reg);
        full = n * n;
        made = 0;
        if (it.op == OP_LOAD_A) begin
            if (left_cnt < full) begin
                left_store[left_cnt % CELLS] = it.element;
                left_cnt++;
                if (left_cnt > left_written)
                    left_written = left_cnt;
            end
        end else if (right_cnt < full) begin
            right_store[right_cnt % CELLS] = it.element;
            right_cnt++;
            if (right_cnt == full) begin
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        acc = 0;
                        for (int k = 0; k < n; k++)
                            acc += longint'(left_store[(i * n + k) % CELLS])
                                 * longint'(right_store[(k * n + j) % CELLS]);
                        r.product = acc[ACC_W-1:0];
                        r.row = IDX_W'(i);
                        r.col = IDX_W'(j);
                        r.last = (i == n - 1) && (j == n - 1);
                        product_q.push_back(r);
                        made++;
                    end
                end
                left_cnt = 0;
                right_cnt = 0;
            end
        end
    endtask

    // Present one item at a falling edge; returns at a falling edge after acceptance
    task automatic send_item(input in_item_t it, input logic typed,
                             input logic signed [ACC_W-1:0] want,
                             output int unsigned made);
        s_item = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_load(it, made);
        if (typed)
            product_q[$].product = want;
        items_sent++;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_valid = 1'b0;
            repeat (idle_len()) @(negedge aclk);
        end
    endtask

    // Size register write and read-back, only once the block has gone quiet
    task automatic write_size(input logic [SIZE_W-1:0] value);
        s_valid = 1'b0;
        while (product_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = SIZE_ADDR;
        pwdata = {{(32 - SIZE_W){1'b0}}, value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        size_reg = value;
        @(negedge aclk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[SIZE_W-1:0] !== value)
            report_mismatch($sformatf("size register read back %0d, written %0d",
                                      prdata[SIZE_W-1:0], value));
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Load until one product fires; noise adds stray and dropped loads
    task automatic run_product(input int noise_pct, input bit shuffle);
        in_item_t    it;
        int unsigned n;
        int unsigned full;
        int unsigned made;
        made = 0;
        while (made == 0) begin
            n = eff_dim(size_reg);
            full = n * n;
            if ($urandom_range(0, 99) < noise_pct)
                it.op = ($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B;
            else if (left_cnt < full && (!shuffle || $urandom_range(0, 1) == 0))
                it.op = OP_LOAD_A;
            else
                it.op = OP_LOAD_B;
            // never let a product read an entry of A that was never written
            if (it.op == OP_LOAD_B && right_cnt + 1 == full && left_written < full)
                it.op = OP_LOAD_A;
            it.element = rand_element();
            send_item(it, 1'b0, '0, made);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            elements_seen++;
            if (m_item.last)
                products_seen++;
            if (product_q.size() == 0) begin
                report_mismatch($sformatf("unexpected element row %0d col %0d product %0d",
                                          m_item.row, m_item.col, m_item.product));
            end else begin
                elem_want = product_q.pop_front();
                if (m_item.product !== elem_want.product)
                    report_mismatch($sformatf("product at (%0d,%0d): got %0d, want %0d",
                                              elem_want.row, elem_want.col,
                                              m_item.product, elem_want.product));
                if (m_item.row !== elem_want.row)
                    report_mismatch($sformatf("row: got %0d, want %0d",
                                              m_item.row, elem_want.row));
                if (m_item.col !== elem_want.col)
                    report_mismatch($sformatf("col: got %0d, want %0d",
                                              m_item.col, elem_want.col));
                if (m_item.last !== elem_want.last)
                    report_mismatch($sformatf("last at (%0d,%0d): got %0b, want %0b",
                                              elem_want.row, elem_want.col,
                                              m_item.last, elem_want.last));
            end
        end
    end

    // Result side back-pressure
    initial begin
        int unsigned stall;
        stall = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall != 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall = idle_len();
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d elements still due",
                 cycle_count, product_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial begin
        in_item_t          it;
        int unsigned       made;
        int unsigned       first_random;
        int                pick;
        logic [SIZE_W-1:0] size;

        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        size_reg = SIZE_RESET;
        left_cnt = 0;
        right_cnt = 0;
        left_written = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        for (int s = 0; s < DIRECTED_STEPS; s++) begin
            if (directed_steps[s].kind == STEP_CONFIG) begin
                write_size(directed_steps[s].size);
            end else begin
                it.op = directed_steps[s].op;
                it.element = directed_steps[s].element;
                send_item(it, directed_steps[s].typed, directed_steps[s].product, made);
            end
        end

        // random products, now and then a large size abandoned part-way
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                write_size(SIZE_W'($urandom_range(5, 15)));
                repeat ($urandom_range(1, 4)) begin
                    // keep B well short of every size's full count
                    if ($urandom_range(0, 1) == 0 || right_cnt >= 8)
                        it.op = OP_LOAD_A;
                    else
                        it.op = OP_LOAD_B;
                    it.element = rand_element();
                    send_item(it, 1'b0, '0, made);
                end
            end else begin
                do begin
                    if ($urandom_range(0, 9) == 0)
                        size = '0;
                    else
                        size = SIZE_W'($urandom_range(1, 4));
                end while (eff_dim(size) * eff_dim(size) <= right_cnt);
                write_size(size);
                if (pick < 60)
                    run_product(0, 1'b0);
                else if (pick < 85)
                    run_product(5, 1'b1);
                else
                    run_product(25, 1'b1);
            end
        end

        // one full-size product, reached through an oversized setting
        quiet = 1'b0;
        write_size(4'd15);
        run_product(0, 1'b0);

        s_valid = 1'b0;
        while (product_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d input items, %0d result elements in %0d products.",
                 items_sent, elements_seen, products_seen);
        $display("Sizes 1 to %0d, element extremes, dropped loads, lone B loads, resizes.",
                 MAX_DIM);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
